### src/cds_pkg.sv
package cds_pkg;

    // Field widths.
    localparam int PW_W    = 16;
    localparam int TICKS_W = 15;
    localparam int CNT_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_REVERSED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_TICKS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS      = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [PW_W-1:0]    THRESHOLD_RST = 16'd3000;
    localparam logic [TICKS_W-1:0] CONFIRM_RST   = 15'd20;
    localparam logic [TICKS_W-1:0] PULSE_RST     = 15'd120;

    typedef enum logic [2:0] {
        PH_ASCENT  = 3'd0,
        PH_CONFIRM = 3'd1,
        PH_CUTTING = 3'd2,
        PH_CUTDONE = 3'd3,
        PH_WAITING = 3'd4
    } cds_phase_t;

    typedef struct packed {
        logic                channel_reversed;
        logic [PW_W-1:0]     pulse_threshold;
        logic [TICKS_W-1:0]  confirm_ticks;
        logic [TICKS_W-1:0]  pulse_ticks;
    } cds_cfg_t;

    typedef struct packed {
        logic manual;
        logic trigger;
    } cds_req_t;

    typedef struct packed {
        logic       cut_out;
        logic       blue_led;
        logic       orange_led;
        cds_phase_t phase;
    } cds_result_t;

endpackage

### src/cds_trigger.sv
module cds_trigger (
    input  logic [cds_pkg::PW_W-1:0] pulse_width,
    input  logic                     link_ok,
    input  cds_pkg::cds_cfg_t        cfg,
    output cds_pkg::cds_req_t        req
);
    import cds_pkg::*;

    logic above;

    // The manual channel is high strictly above the threshold, flipped when reversed.
    always_comb begin
        above       = pulse_width > cfg.pulse_threshold;
        req.manual  = above ^ cfg.channel_reversed;
        req.trigger = req.manual | ~link_ok;
    end

endmodule

### src/cds_fsm.sv
module cds_fsm (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  cds_pkg::cds_req_t     req,
    input  cds_pkg::cds_cfg_t     cfg,
    output cds_pkg::cds_result_t  res
);
    import cds_pkg::*;

    cds_phase_t       phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             cut_reg, cut_next;
    logic             blue_reg, blue_next;
    logic [CNT_W-1:0] confirm_load;
    logic [CNT_W-1:0] pulse_load;

    assign confirm_load = {1'b0, cfg.confirm_ticks};
    assign pulse_load   = {1'b0, cfg.pulse_ticks};

    // State registers advance once per processed word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_ASCENT;
            count_reg <= {1'b0, CONFIRM_RST};
            cut_reg   <= 1'b0;
            blue_reg  <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            cut_reg   <= cut_next;
            blue_reg  <= blue_next;
        end
    end

    // Next phase, countdown and latches for the current word.
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        cut_next   = cut_reg;
        blue_next  = blue_reg;
        case (phase_reg)
            PH_CONFIRM: begin
                if (req.trigger) begin
                    if (count_reg == '0) begin
                        count_next = pulse_load;
                        phase_next = PH_CUTTING;
                    end else begin
                        count_next = count_reg - 1'b1;
                    end
                end else begin
                    count_next = confirm_load;
                    phase_next = PH_ASCENT;
                end
            end
            PH_CUTTING: begin
                cut_next   = 1'b1;
                blue_next  = 1'b1;
                count_next = count_reg - 1'b1;
                if (count_reg == '0) begin
                    phase_next = PH_CUTDONE;
                end
            end
            PH_CUTDONE: begin
                cut_next  = 1'b0;
                blue_next = 1'b0;
                if (!req.trigger) begin
                    count_next = confirm_load;
                    phase_next = PH_WAITING;
                end
            end
            PH_WAITING: begin
                if (req.manual) begin
                    phase_next = PH_CONFIRM;
                end else begin
                    count_next = confirm_load;
                end
            end
            default: begin
                if (req.trigger) begin
                    phase_next = PH_CONFIRM;
                end else begin
                    count_next = confirm_load;
                end
            end
        endcase
    end

    // The result reports the state after this word.
    always_comb begin
        res.cut_out    = cut_next;
        res.blue_led   = blue_next;
        res.orange_led = req.trigger;
        res.phase      = phase_next;
    end

endmodule

### src/cut_down_sequencer.sv
// Channel  Direction  Handshake          Word
// s_       in         s_valid/s_ready    pulse_width, link_ok
// m_       out        m_valid/m_ready    cut_out, blue_led, orange_led, phase
// cfg_     in         cfg_wr_en          cfg_index, cfg_wdata
//
// One word is accepted per cycle while s_ready is high; its result passes
// through the input register, which loads at acceptance, and then the result
// register, which loads when the word steps through the FSM.
// Reset is synchronous on aresetn and restores the register defaults and ascent.
// A stalled result holds the result register and the input register; the input
// side takes a new word whenever the input register is empty or moving on.
module cut_down_sequencer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [cds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cds_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [cds_pkg::PW_W-1:0]       s_pulse_width,
    input  logic                           s_link_ok,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_cut_out,
    output logic                           m_blue_led,
    output logic                           m_orange_led,
    output logic [2:0]                     m_phase
);
    import cds_pkg::*;

    cds_cfg_t        cfg_reg;
    logic            in_valid_reg;
    logic [PW_W-1:0] pw_reg;
    logic            radio_reg;
    logic            out_valid_reg;
    cds_result_t     out_reg;
    cds_req_t        req;
    cds_result_t     res;
    logic            advance;
    logic            step;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channel_reversed <= 1'b0;
            cfg_reg.pulse_threshold  <= THRESHOLD_RST;
            cfg_reg.confirm_ticks    <= CONFIRM_RST;
            cfg_reg.pulse_ticks      <= PULSE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CHANNEL_REVERSED: cfg_reg.channel_reversed <= cfg_wdata[0];
                REG_PULSE_THRESHOLD:  cfg_reg.pulse_threshold  <= cfg_wdata;
                REG_CONFIRM_TICKS:    cfg_reg.confirm_ticks    <= cfg_wdata[TICKS_W-1:0];
                REG_PULSE_TICKS:      cfg_reg.pulse_ticks      <= cfg_wdata[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // The result register can take a word when empty or when it is being read.
    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pw_reg    <= s_pulse_width;
            radio_reg <= s_link_ok;
        end
    end

    cds_trigger u_trigger (
        .pulse_width (pw_reg),
        .link_ok     (radio_reg),
        .cfg         (cfg_reg),
        .req         (req)
    );

    cds_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .req     (req),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_cut_out    = out_reg.cut_out;
    assign m_blue_led   = out_reg.blue_led;
    assign m_orange_led = out_reg.orange_led;
    assign m_phase      = out_reg.phase;

endmodule
